[design/bgc_pkg.sv]
package bgc_pkg;

    typedef enum logic [2:0] {
        EV_DOWN     = 3'd0,
        EV_HOLD     = 3'd1,
        EV_LONG     = 3'd2,
        EV_RELEASED = 3'd3,
        EV_SHORT    = 3'd4,
        EV_MULTI    = 3'd5
    } event_kind_t;

    // Register indexes of the configuration port.
    localparam logic [3:0] REG_ACTIVE_LOW    = 4'd0;
    localparam logic [3:0] REG_LONG_PRESS_MS = 4'd1;
    localparam logic [3:0] REG_TAP_WINDOW_MS = 4'd2;
    localparam logic [3:0] REG_TAP_THRESHOLD = 4'd3;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    localparam logic [15:0] DEF_LONG_MS   = 16'd3000;
    localparam logic [15:0] DEF_WINDOW_MS = 16'd800;
    localparam logic [7:0]  DEF_THRESHOLD = 8'd5;

    // Fixed hold thresholds in milliseconds, ascending.
    localparam int NUM_THRESH = 4;
    localparam logic [NUM_THRESH-1:0][31:0] HOLD_MS =
        {32'd10000, 32'd5000, 32'd3000, 32'd1000};

    // Event slots of one sample, in delivery order.
    localparam int SLOT_DOWN  = 0;
    localparam int SLOT_HOLD0 = 1;
    localparam int SLOT_LONG  = SLOT_HOLD0 + NUM_THRESH;
    localparam int SLOT_REL   = SLOT_LONG + 1;
    localparam int SLOT_SHORT = SLOT_REL + 1;
    localparam int SLOT_MULTI = SLOT_SHORT + 1;
    localparam int NUM_SLOTS  = SLOT_MULTI + 1;
    localparam int SLOT_IDX_W = $clog2(NUM_SLOTS);

    // All events that one sample raises, with the values they carry.
    typedef struct packed {
        logic [NUM_SLOTS-1:0] mask;
        logic [31:0]          held;
        logic [7:0]           taps;
    } bundle_t;

endpackage

[design/bgc_intf.sv]
interface bgc_in_if;
    logic        valid;
    logic        ready;
    logic        pin_level;
    logic [31:0] now_ms;

    modport source (output valid, output pin_level, output now_ms, input ready);
    modport sink   (input valid, input pin_level, input now_ms, output ready);
endinterface

interface bgc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_kind;
    logic [31:0] event_value;
    logic        last_event;

    modport source (output valid, output event_kind, output event_value,
                    output last_event, input ready);
    modport sink   (input valid, input event_kind, input event_value,
                    input last_event, output ready);
endinterface

[design/bgc_classify.sv]
module bgc_classify #(
    parameter int HOLD_LEVELS      = 4,
    parameter int DEBOUNCE_TIME_MS = 30
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bgc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bgc_pkg::CFG_DATA_W-1:0]  cfg_data,
    bgc_in_if.sink                         samples,
    input  logic                           free,
    output logic                           load,
    output bgc_pkg::bundle_t               bundle
);

    localparam int LEVELS = (HOLD_LEVELS < bgc_pkg::NUM_THRESH) ?
                            HOLD_LEVELS : bgc_pkg::NUM_THRESH;
    localparam logic [31:0] DEBOUNCE = 32'(DEBOUNCE_TIME_MS);

    // Configuration registers.
    logic        active_low_reg;
    logic [15:0] long_ms_reg;
    logic [15:0] window_ms_reg;
    logic [7:0]  threshold_reg;

    // Input register.
    logic        in_valid_reg, in_valid_next;
    logic        level_reg;
    logic [31:0] now_reg;

    // Gesture state.
    logic              was_pressed_reg, was_pressed_next;
    logic [31:0]       press_start_reg, press_start_next;
    logic              down_done_reg, down_done_next;
    logic              long_done_reg, long_done_next;
    logic [LEVELS-1:0] hold_done_reg, hold_done_next;
    logic [7:0]        tap_count_reg, tap_count_next;
    logic [31:0]       first_tap_reg, first_tap_next;

    logic              accept;
    logic              pressed;
    logic              press_edge;
    logic [31:0]       held;
    logic              down_eff;
    logic              long_eff;
    logic [LEVELS-1:0] hold_eff;
    logic              released;
    logic              short_ev;
    logic              expired;
    logic [7:0]        tap_inc;
    logic              multi_ev;
    logic [bgc_pkg::NUM_SLOTS-1:0] mask;

    assign accept        = samples.valid && samples.ready;
    assign load          = in_valid_reg && free;
    assign samples.ready = !in_valid_reg || free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_low_reg <= 1'b0;
            long_ms_reg    <= bgc_pkg::DEF_LONG_MS;
            window_ms_reg  <= bgc_pkg::DEF_WINDOW_MS;
            threshold_reg  <= bgc_pkg::DEF_THRESHOLD;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bgc_pkg::REG_ACTIVE_LOW:
                    active_low_reg <= cfg_data[0];
                bgc_pkg::REG_LONG_PRESS_MS:
                    long_ms_reg <= (cfg_data != 16'd0) ? cfg_data : bgc_pkg::DEF_LONG_MS;
                bgc_pkg::REG_TAP_WINDOW_MS:
                    window_ms_reg <= (cfg_data != 16'd0) ? cfg_data : bgc_pkg::DEF_WINDOW_MS;
                bgc_pkg::REG_TAP_THRESHOLD:
                    threshold_reg <= (cfg_data[7:0] != 8'd0) ? cfg_data[7:0] :
                                     bgc_pkg::DEF_THRESHOLD;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (load)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            level_reg <= samples.pin_level;
            now_reg   <= samples.now_ms;
        end
    end

    // A new press restarts the timer and clears the per-press flags
    // before any comparison is made.
    always_comb
    begin
        pressed    = active_low_reg ? !level_reg : level_reg;
        press_edge = pressed && !was_pressed_reg;
        press_start_next = press_edge ? now_reg : press_start_reg;
        down_eff   = press_edge ? 1'b0 : down_done_reg;
        long_eff   = press_edge ? 1'b0 : long_done_reg;
        hold_eff   = press_edge ? '0 : hold_done_reg;
        held       = now_reg - press_start_next;

        mask           = '0;
        down_done_next = down_eff;
        long_done_next = long_eff;
        hold_done_next = hold_eff;

        if (pressed)
        begin
            if (!down_eff && held >= DEBOUNCE)
            begin
                mask[bgc_pkg::SLOT_DOWN] = 1'b1;
                down_done_next           = 1'b1;
            end
            for (int i = 0; i < LEVELS; i++)
            begin
                if (!hold_eff[i] && held >= bgc_pkg::HOLD_MS[i])
                begin
                    mask[bgc_pkg::SLOT_HOLD0 + i] = 1'b1;
                    hold_done_next[i]             = 1'b1;
                end
            end
            if (!long_eff && held >= {16'd0, long_ms_reg})
            begin
                mask[bgc_pkg::SLOT_LONG] = 1'b1;
                long_done_next           = 1'b1;
            end
        end

        // Releases shorter than the debounce time are glitches and are dropped.
        released = !pressed && was_pressed_reg && held >= DEBOUNCE;
        short_ev = released && !long_done_reg;
        expired  = (tap_count_reg == 8'd0) ||
                   ((now_reg - first_tap_reg) > {16'd0, window_ms_reg});
        tap_inc  = tap_count_reg + 8'd1;
        multi_ev = short_ev && !expired && (tap_inc >= threshold_reg);

        tap_count_next = tap_count_reg;
        first_tap_next = first_tap_reg;
        if (short_ev)
        begin
            if (expired)
            begin
                first_tap_next = now_reg;
                tap_count_next = 8'd1;
            end
            else if (multi_ev)
                tap_count_next = 8'd0;
            else
                tap_count_next = tap_inc;
        end

        mask[bgc_pkg::SLOT_REL]   = released;
        mask[bgc_pkg::SLOT_SHORT] = short_ev;
        mask[bgc_pkg::SLOT_MULTI] = multi_ev;
        was_pressed_next          = pressed;

        bundle.mask = mask;
        bundle.held = held;
        bundle.taps = tap_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            was_pressed_reg <= 1'b0;
            press_start_reg <= 32'd0;
            down_done_reg   <= 1'b0;
            long_done_reg   <= 1'b0;
            hold_done_reg   <= '0;
            tap_count_reg   <= 8'd0;
            first_tap_reg   <= 32'd0;
        end
        else if (load)
        begin
            was_pressed_reg <= was_pressed_next;
            press_start_reg <= press_start_next;
            down_done_reg   <= down_done_next;
            long_done_reg   <= long_done_next;
            hold_done_reg   <= hold_done_next;
            tap_count_reg   <= tap_count_next;
            first_tap_reg   <= first_tap_next;
        end
    end

`ifndef SYNTHESIS
    a_press_release_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !(mask[bgc_pkg::SLOT_REL] &&
                   (mask[bgc_pkg::SLOT_DOWN] || mask[bgc_pkg::SLOT_LONG])))
        else $error("press and release events raised by one sample");
    a_multi_needs_short: assert property (@(posedge clk) disable iff (!rst_n)
        load && mask[bgc_pkg::SLOT_MULTI] |-> mask[bgc_pkg::SLOT_SHORT])
        else $error("multi tap without short press");
    a_short_needs_release: assert property (@(posedge clk) disable iff (!rst_n)
        load && mask[bgc_pkg::SLOT_SHORT] |-> mask[bgc_pkg::SLOT_REL])
        else $error("short press without release");
    a_long_marks_done: assert property (@(posedge clk) disable iff (!rst_n)
        load && mask[bgc_pkg::SLOT_LONG] |=> long_done_reg)
        else $error("long press reported but not remembered");
`endif

endmodule

[design/bgc_serialize.sv]
module bgc_serialize (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  bgc_pkg::bundle_t bundle,
    output logic             free,
    bgc_out_if.source        events
);

    logic [bgc_pkg::NUM_SLOTS-1:0] mask_reg, mask_next;
    logic [31:0]                   held_reg;
    logic [7:0]                    taps_reg;

    logic [bgc_pkg::NUM_SLOTS-1:0]  low_bit;
    logic [bgc_pkg::SLOT_IDX_W-1:0] slot;
    logic                           last;
    logic                           beat;
    logic [1:0]                     hold_idx;

    assign low_bit = mask_reg & (~mask_reg + 1'b1);
    assign last    = (mask_reg & ~low_bit) == '0;
    assign beat    = events.valid && events.ready;
    assign free    = (mask_reg == '0) || (last && events.ready);

    always_comb
    begin
        slot = '0;
        for (int i = 0; i < bgc_pkg::NUM_SLOTS; i++)
        begin
            if (low_bit[i])
                slot = bgc_pkg::SLOT_IDX_W'(i);
        end
    end

    assign hold_idx = 2'(slot - bgc_pkg::SLOT_IDX_W'(bgc_pkg::SLOT_HOLD0));

    always_comb
    begin
        events.valid      = mask_reg != '0;
        events.last_event = last;
        events.event_value = held_reg;
        events.event_kind  = bgc_pkg::EV_DOWN;
        if (slot == bgc_pkg::SLOT_IDX_W'(bgc_pkg::SLOT_MULTI))
        begin
            events.event_kind  = bgc_pkg::EV_MULTI;
            events.event_value = {24'd0, taps_reg};
        end
        else if (slot == bgc_pkg::SLOT_IDX_W'(bgc_pkg::SLOT_SHORT))
            events.event_kind = bgc_pkg::EV_SHORT;
        else if (slot == bgc_pkg::SLOT_IDX_W'(bgc_pkg::SLOT_REL))
            events.event_kind = bgc_pkg::EV_RELEASED;
        else if (slot == bgc_pkg::SLOT_IDX_W'(bgc_pkg::SLOT_LONG))
            events.event_kind = bgc_pkg::EV_LONG;
        else if (slot != bgc_pkg::SLOT_IDX_W'(bgc_pkg::SLOT_DOWN))
        begin
            events.event_kind  = bgc_pkg::EV_HOLD;
            events.event_value = bgc_pkg::HOLD_MS[hold_idx];
        end
    end

    always_comb
    begin
        mask_next = mask_reg;
        if (load)
            mask_next = bundle.mask;
        else if (beat)
            mask_next = mask_reg & ~low_bit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mask_reg <= '0;
        else
            mask_reg <= mask_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            held_reg <= bundle.held;
            taps_reg <= bundle.taps;
        end
    end

`ifndef SYNTHESIS
    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("bundle loaded over undelivered events");
    a_beat_drops_one_slot: assert property (@(posedge clk) disable iff (!rst_n)
        beat && !load |=> $countones(mask_reg) == $countones($past(mask_reg)) - 1)
        else $error("delivered beat did not retire exactly one slot");
    a_last_is_single: assert property (@(posedge clk) disable iff (!rst_n)
        events.valid && events.last_event |-> $onehot(mask_reg))
        else $error("last beat flagged with further events pending");
`endif

endmodule

[design/button_gesture_classifier.sv]
// Button gesture classifier: poll samples in, gesture events out.
// A sample passes the input register and then the mask register before its first beat.
// Throughput: one sample per cycle when it raises at most one event and events.ready is high;
// a sample with more events holds the input until its last beat, one beat a cycle while ready.
// Reset (rst_n, asynchronous, active low) restores the register defaults and clears the valid flags and gesture state.
module button_gesture_classifier #(
    parameter int HOLD_LEVELS      = 4,
    parameter int DEBOUNCE_TIME_MS = 30
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bgc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bgc_pkg::CFG_DATA_W-1:0]  cfg_data,
    bgc_in_if.sink                          samples,
    bgc_out_if.source                       events
);

    // The classifier holds one sample in its input register and, in a single
    // pass of logic, works out every event that sample raises together with
    // the updated gesture state. The events land as a slot mask in the
    // serialiser, which hands them out one beat per cycle while events.ready is high, in the order
    // down, holds, long press, released, short press, multi tap.
    logic             free;
    logic             load;
    bgc_pkg::bundle_t bundle;

    // The classifier commits a sample only when the serialiser can take its
    // events, that is when it is empty or is delivering its final beat.
    bgc_classify #(
        .HOLD_LEVELS      (HOLD_LEVELS),
        .DEBOUNCE_TIME_MS (DEBOUNCE_TIME_MS)
    ) u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (samples),
        .free      (free),
        .load      (load),
        .bundle    (bundle)
    );

    bgc_serialize u_serialize (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load),
        .bundle (bundle),
        .free   (free),
        .events (events)
    );

endmodule

[tb/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bgc_pkg::*;

    // The block is built with its default parameters; the predictor below
    // uses the same values.
    localparam int HOLD_LEVELS      = 4;
    localparam int DEBOUNCE_TIME_MS = 30;
    localparam int HOLD_USED        = (HOLD_LEVELS < NUM_THRESH) ? HOLD_LEVELS : NUM_THRESH;
    localparam int NUM_REGS         = 4;

    // Run shape.
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 8;     // covers the input and mask registers with margin
    localparam int QUIET_LIMIT   = 1000;  // cycles without any handshake or register write before giving up
    localparam int RANDOM_ITEMS  = 170;
    localparam int PHASE_ITEMS   = 30;

    // Receiver stall pattern used in one of its four modes.
    localparam logic [7:0] STALL_PATTERN = 8'b1011_0110;

    // One expected event beat.
    typedef struct {
        event_kind_t kind;
        logic [31:0] value;
        logic        last;
    } gesture_event_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    bgc_in_if  sample_ch();
    bgc_out_if event_ch();

    button_gesture_classifier #(
        .HOLD_LEVELS      (HOLD_LEVELS),
        .DEBOUNCE_TIME_MS (DEBOUNCE_TIME_MS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (sample_ch),
        .events    (event_ch)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the registers and of the gesture
    // tracking, updated as each sample is accepted.
    // ------------------------------------------------------------------
    logic        cfg_active_low;
    logic [15:0] cfg_long_ms;
    logic [15:0] cfg_window_ms;
    logic [7:0]  cfg_tap_threshold;

    logic        btn_was_pressed;
    logic [31:0] press_start_ms;
    logic        down_sent;
    logic        long_sent;
    logic [NUM_THRESH-1:0] hold_sent;
    logic [7:0]  tap_count;
    logic [31:0] first_tap_ms;

    gesture_event_t expected_events[$];

    // Bookkeeping.
    int unsigned mismatch_count = 0;
    int unsigned samples_sent   = 0;
    int unsigned settings_used  = 0;
    int unsigned kind_seen [0:7];
    int unsigned quiet_cycles   = 0;

    // Sender shaping: bursts of random length, with the gaps switched off
    // for whole phases now and then.
    int unsigned burst_left = 0;
    bit          gapless    = 1'b0;

    // Free-running millisecond clock that the stimulus walks forward.
    logic [31:0] clock_ms;

    function automatic void queue_event(input event_kind_t kind, input logic [31:0] value);
        gesture_event_t ev;
        ev.kind  = kind;
        ev.value = value;
        ev.last  = 1'b0;
        expected_events.push_back(ev);
    endfunction

    // Works out every event beat that one accepted sample should raise, in
    // delivery order, and appends them to the expectation queue. The last
    // beat of the sample carries the last_event flag.
    function automatic void classify_sample(input logic level, input logic [31:0] now);
        logic        pressed;
        logic [31:0] held;
        int unsigned queued_at_entry;
        queued_at_entry = expected_events.size();
        pressed = cfg_active_low ? ~level : level;

        // A fresh press restarts the held-time reference and the per-press flags.
        if (pressed && !btn_was_pressed)
        begin
            press_start_ms = now;
            down_sent      = 1'b0;
            long_sent      = 1'b0;
            hold_sent      = '0;
        end

        // Held time wraps with the timestamp.
        held = now - press_start_ms;

        if (pressed)
        begin
            if (!down_sent && held >= DEBOUNCE_TIME_MS)
            begin
                down_sent = 1'b1;
                queue_event(EV_DOWN, held);
            end
            for (int i = 0; i < HOLD_USED; i++)
            begin
                if (!hold_sent[i] && held >= HOLD_MS[i])
                begin
                    hold_sent[i] = 1'b1;
                    queue_event(EV_HOLD, HOLD_MS[i]);
                end
            end
            if (!long_sent && held >= {16'd0, cfg_long_ms})
            begin
                long_sent = 1'b1;
                queue_event(EV_LONG, held);
            end
        end
        else if (btn_was_pressed && held >= DEBOUNCE_TIME_MS)
        begin
            // A release shorter than the debounce time is a glitch and is
            // dropped above without touching the tap state.
            queue_event(EV_RELEASED, held);
            if (!long_sent)
            begin
                queue_event(EV_SHORT, held);
                if (tap_count == 8'd0 || (now - first_tap_ms) > {16'd0, cfg_window_ms})
                begin
                    // The first tap, or one after the window has run out,
                    // only starts a new count.
                    first_tap_ms = now;
                    tap_count    = 8'd1;
                end
                else
                begin
                    tap_count = tap_count + 8'd1;
                    if (tap_count >= cfg_tap_threshold)
                    begin
                        queue_event(EV_MULTI, {24'd0, tap_count});
                        tap_count = 8'd0;
                    end
                end
            end
        end

        btn_was_pressed = pressed;
        if (expected_events.size() > queued_at_entry)
            expected_events[expected_events.size() - 1].last = 1'b1;
    endfunction

    // Pin level that reads as the wanted button state under the current polarity.
    function automatic logic pin_for(input logic pressed);
        return pressed ^ cfg_active_low;
    endfunction

    // ------------------------------------------------------------------
    // Configuration port. Writes are only issued while the block is idle.
    // The write enable is left high between back-to-back writes and lowered
    // by the caller once the sequence is done.
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        // Bits above each register's width are dropped, and a written zero
        // falls back to the register's default.
        case (index)
            REG_ACTIVE_LOW:    cfg_active_low    = data[0];
            REG_LONG_PRESS_MS: cfg_long_ms       = (data == 16'd0) ? DEF_LONG_MS : data;
            REG_TAP_WINDOW_MS: cfg_window_ms     = (data == 16'd0) ? DEF_WINDOW_MS : data;
            REG_TAP_THRESHOLD: cfg_tap_threshold =
                                   (data[7:0] == 8'd0) ? DEF_THRESHOLD : data[7:0];
            default: ;
        endcase
    endtask

    // Writes all four registers, then one index beyond the register map,
    // which the block must ignore.
    task automatic configure(input logic [15:0] al_word, input logic [15:0] long_word,
                             input logic [15:0] win_word, input logic [15:0] thr_word);
        logic [CFG_INDEX_W-1:0] stray_index;
        stray_index = CFG_INDEX_W'($urandom_range(NUM_REGS, (1 << CFG_INDEX_W) - 1));
        write_reg(REG_ACTIVE_LOW, al_word);
        write_reg(REG_LONG_PRESS_MS, long_word);
        write_reg(REG_TAP_WINDOW_MS, win_word);
        write_reg(REG_TAP_THRESHOLD, thr_word);
        write_reg(stray_index, 16'($urandom()));
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // Sample sender. Valid is left high after a beat so that the next
    // sample can follow on the very next cycle; gaps are inserted between
    // bursts unless the current phase runs gapless.
    // ------------------------------------------------------------------
    task automatic send_sample(input logic level, input logic [31:0] now);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if (!gapless && $urandom_range(0, 3) != 0)
            begin
                sample_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
        end
        sample_ch.valid     <= 1'b1;
        sample_ch.pin_level <= level;
        sample_ch.now_ms    <= now;
        do @(posedge clk); while (!sample_ch.ready);
        burst_left--;
        samples_sent++;
        classify_sample(level, now);
    endtask

    // Lets every outstanding event beat arrive, then a few more cycles so
    // that a sample raising no event has certainly left the pipeline.
    task automatic wait_until_idle();
        sample_ch.valid <= 1'b0;
        burst_left = 0;
        while (expected_events.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One press held for held_ms with a few polls in between, then the release.
    task automatic press_and_release(input int unsigned held_ms, input int unsigned mid_samples);
        logic [31:0] t0;
        t0 = clock_ms;
        send_sample(pin_for(1'b1), t0);
        for (int unsigned k = 1; k <= mid_samples; k++)
            send_sample(pin_for(1'b1), t0 + held_ms * k / (mid_samples + 1));
        clock_ms = t0 + held_ms;
        send_sample(pin_for(1'b0), clock_ms);
    endtask

    // ------------------------------------------------------------------
    // Directed tests.
    // ------------------------------------------------------------------

    // Reset values: active-high pin, long press at 3000 ms. A single poll
    // far into the press raises the whole ladder at once: down, the four
    // hold thresholds and long press, six beats from one sample.
    task automatic test_reset_defaults();
        clock_ms = 32'h0000_1000;
        send_sample(1'b1, clock_ms);
        send_sample(1'b1, clock_ms + 32'd20000);
        send_sample(1'b0, clock_ms + 32'd20010);
        wait_until_idle();
    endtask

    // Active-low pin and the shortest long press: long press is reported
    // before down, and the release that follows gives no short press.
    task automatic test_polarity_early_long();
        configure(16'h0001, 16'd1, DEF_WINDOW_MS, {8'd0, DEF_THRESHOLD});
        clock_ms = 32'h0001_0000;
        send_sample(1'b0, clock_ms);
        send_sample(1'b0, clock_ms + 32'd5);
        send_sample(1'b0, clock_ms + 32'd30);
        send_sample(1'b1, clock_ms + 32'd31);
        wait_until_idle();
    endtask

    // Upper data bits are ignored and zeros load defaults. A glitch release
    // changes nothing; with a threshold of one the first tap only starts the
    // count and the second fires multi-tap.
    task automatic test_taps_and_glitch();
        configure(16'hFFFE, 16'h0000, 16'hFFFF, 16'hAB01);
        clock_ms = 32'h0002_0000;
        send_sample(1'b1, clock_ms);
        send_sample(1'b0, clock_ms + 32'd10);
        send_sample(1'b1, clock_ms + 32'd20);
        send_sample(1'b0, clock_ms + 32'd60);
        send_sample(1'b1, clock_ms + 32'd100);
        send_sample(1'b1, clock_ms + 32'd130);
        send_sample(1'b0, clock_ms + 32'd140);
        wait_until_idle();
    endtask

    // Timestamps wrap through zero, the longest long press, and a one
    // millisecond window that has always expired by the next tap.
    task automatic test_wrap_and_window();
        configure(16'h0000, 16'hFFFF, 16'h0001, 16'h0000);
        send_sample(1'b1, 32'hFFFF_FFF0);
        send_sample(1'b0, 32'h0000_0020);
        send_sample(1'b1, 32'h0000_0100);
        send_sample(1'b1, 32'h0001_1200);
        send_sample(1'b0, 32'h0001_1210);
        send_sample(1'b1, 32'h0001_1300);
        send_sample(1'b0, 32'h0001_1340);
        wait_until_idle();
    endtask

    // ------------------------------------------------------------------
    // Random gestures: mostly well-formed taps and holds, with glitches,
    // very long holds, quiet polls and random-level noise with arbitrary
    // time jumps mixed in.
    // ------------------------------------------------------------------
    task automatic random_gesture();
        logic [31:0] jump;
        case ($urandom_range(0, 11))
            0, 1, 2, 3, 4:
            begin
                press_and_release($urandom_range(30, 400), $urandom_range(0, 2));
                clock_ms += $urandom_range(1, 400);
            end
            5, 6:
                press_and_release($urandom_range(900, 12000), $urandom_range(1, 5));
            7:
                press_and_release($urandom_range(60000, 70000), $urandom_range(1, 3));
            8:
            begin
                press_and_release($urandom_range(0, DEBOUNCE_TIME_MS - 1), 0);
                clock_ms += $urandom_range(1, 100);
            end
            9:
            begin
                jump = $urandom();
                clock_ms += jump;
                send_sample(1'($urandom_range(0, 1)), clock_ms);
            end
            default:
            begin
                clock_ms += $urandom_range(1, 50);
                send_sample(pin_for(1'b0), clock_ms);
            end
        endcase
    endtask

    // Each phase picks a register setting, extremes included, then plays
    // gestures until enough samples have gone in.
    task automatic test_random_gestures();
        logic [15:0] long_word;
        logic [15:0] win_word;
        logic [15:0] thr_word;
        int unsigned random_start;
        int unsigned phase_start;
        random_start = samples_sent;
        while (samples_sent - random_start < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 4))
                0:       long_word = 16'd1;
                1:       long_word = 16'hFFFF;
                2:       long_word = 16'd0;
                default: long_word = 16'($urandom_range(200, 6000));
            endcase
            case ($urandom_range(0, 4))
                0:       win_word = 16'd1;
                1:       win_word = 16'hFFFF;
                2:       win_word = 16'd0;
                default: win_word = 16'($urandom_range(100, 1500));
            endcase
            thr_word = 16'($urandom());
            case ($urandom_range(0, 5))
                0:       thr_word[7:0] = 8'd1;
                1:       thr_word[7:0] = 8'd255;
                2:       thr_word[7:0] = 8'd0;
                default: thr_word[7:0] = 8'($urandom_range(2, 6));
            endcase
            configure(16'($urandom()), long_word, win_word, thr_word);

            gapless  = ($urandom_range(0, 2) == 0);
            clock_ms = $urandom();
            phase_start = samples_sent;
            while (samples_sent - phase_start < PHASE_ITEMS)
                random_gesture();
            wait_until_idle();
        end
        gapless = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Event receiver: stalls follow one of four modes that rotate in turn,
    // namely always ready, random stalls, a fixed pattern and long
    // stretches low, so that stalls land on every beat position.
    // ------------------------------------------------------------------
    initial
    begin : event_receiver
        int unsigned cyc;
        int unsigned hold_cnt;
        logic        level;
        cyc      = 0;
        hold_cnt = 0;
        level    = 1'b0;
        event_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            case ((cyc / 64) % 4)
                0: level = 1'b1;
                1: level = ($urandom_range(0, 3) != 0);
                2: level = STALL_PATTERN[cyc % 8];
                default:
                begin
                    if (hold_cnt == 0)
                    begin
                        level    = ~level;
                        hold_cnt = level ? $urandom_range(1, 4) : $urandom_range(1, 8);
                    end
                    else
                        hold_cnt--;
                end
            endcase
            event_ch.ready <= level;
            cyc++;
        end
    end

    // ------------------------------------------------------------------
    // Event checker: every accepted beat is compared, field by field,
    // against the oldest expectation. A beat with nothing expected is an
    // error in its own right.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : event_checker
        gesture_event_t want;
        if (rst_n && event_ch.valid && event_ch.ready)
        begin
            if (!$isunknown(event_ch.event_kind))
                kind_seen[event_ch.event_kind]++;
            if (expected_events.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected event beat, expected none, got kind %0d value %0d last %0d",
                         $time, event_ch.event_kind, event_ch.event_value, event_ch.last_event);
            end
            else
            begin
                want = expected_events.pop_front();
                if (event_ch.event_kind !== want.kind)
                begin
                    mismatch_count++;
                    $display("%0t: event_kind mismatch, expected %0d, got %0d",
                             $time, want.kind, event_ch.event_kind);
                end
                if (event_ch.event_value !== want.value)
                begin
                    mismatch_count++;
                    $display("%0t: event_value mismatch, expected %0d, got %0d",
                             $time, want.value, event_ch.event_value);
                end
                if (event_ch.last_event !== want.last)
                begin
                    mismatch_count++;
                    $display("%0t: last_event mismatch, expected %0d, got %0d",
                             $time, want.last, event_ch.last_event);
                end
            end
        end
    end

    // Watchdog: any handshake or register write counts as progress.
    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (event_ch.valid && event_ch.ready) || cfg_we)
            quiet_cycles <= 0;
        else if (rst_n)
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: watchdog expired after %0d cycles without a handshake",
                         $time, quiet_cycles);
                $display("FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= '0;
        cfg_data            <= '0;
        sample_ch.valid     <= 1'b0;
        sample_ch.pin_level <= 1'b0;
        sample_ch.now_ms    <= '0;

        // Predictor starts from the reset values.
        cfg_active_low    = 1'b0;
        cfg_long_ms       = DEF_LONG_MS;
        cfg_window_ms     = DEF_WINDOW_MS;
        cfg_tap_threshold = DEF_THRESHOLD;
        btn_was_pressed   = 1'b0;
        press_start_ms    = '0;
        down_sent         = 1'b0;
        long_sent         = 1'b0;
        hold_sent         = '0;
        tap_count         = '0;
        first_tap_ms      = '0;
        foreach (kind_seen[i])
            kind_seen[i] = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_polarity_early_long();
        test_taps_and_glitch();
        test_wrap_and_window();
        test_random_gestures();

        $display("Run covered %0d samples across %0d register settings, bursty input, stalled output.",
                 samples_sent, settings_used);
        $display("Beats seen: down %0d, hold %0d, long %0d, released %0d, short %0d, multi-tap %0d.",
                 kind_seen[EV_DOWN], kind_seen[EV_HOLD], kind_seen[EV_LONG],
                 kind_seen[EV_RELEASED], kind_seen[EV_SHORT], kind_seen[EV_MULTI]);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
